>>> rtl/core/orb_pkg.sv
`default_nettype none

package orb_pkg;

  localparam int CAPACITY_DEF    = 256;
  localparam int RECORD_BITS_DEF = 64;
  localparam int DATA_W          = 64;
  localparam int RES_DEPTH       = 4;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_READ  = 2'd1,
    OP_DROP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e               opcode;
    logic [DATA_W-1:0] record_data;
    logic [7:0]        position;
    logic [8:0]        drop_request;
  } in_item_t;

  typedef struct packed {
    logic              found;
    logic [DATA_W-1:0] read_data;
    logic [8:0]        dropped_now;
    logic [8:0]        fill_count;
    logic [31:0]       lost_total;
  } out_item_t;

  // front to back: one transaction whose memory access is in flight
  typedef struct packed {
    logic        valid;
    logic        found;
    logic [8:0]  dropped_now;
    logic [8:0]  fill_count;
    logic [31:0] lost_total;
  } stage_t;

endpackage

`default_nettype wire

>>> rtl/core/orb_ram.sv
`default_nettype none

module orb_ram #(
  parameter int WIDTH = orb_pkg::RECORD_BITS_DEF,
  parameter int DEPTH = orb_pkg::CAPACITY_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[addr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/orb_front.sv
`default_nettype none

module orb_front #(
  parameter int CAPACITY    = orb_pkg::CAPACITY_DEF,
  parameter int RECORD_BITS = orb_pkg::RECORD_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        push,
  input  wire logic                        full_i,
  input  wire orb_pkg::in_item_t           in_item_i,
  output logic                             ram_we_o,
  output logic                             ram_re_o,
  output logic [$clog2(CAPACITY)-1:0]      ram_addr_o,
  output logic [RECORD_BITS-1:0]           ram_wdata_o,
  output orb_pkg::stage_t                  stage_o
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int SW = ((CW > 9) ? CW : 9) + 1;

  logic [AW-1:0]   head_q, head_d;
  logic [CW-1:0]   count_q, count_d;
  logic [31:0]     lost_q, lost_d;
  orb_pkg::stage_t stage_q, stage_d;

  logic            item_accept;
  logic            is_full;
  logic            found;
  logic [SW-1:0]   head_ext, count_ext, pos_ext, req_ext, drop_n, dropped;

  function automatic logic [AW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= SW'(CAPACITY)) ? (s - SW'(CAPACITY)) : s;
    return r[AW-1:0];
  endfunction

  assign item_accept = push & ~full_i;
  assign is_full     = (count_q == CW'(CAPACITY));
  assign head_ext    = SW'(head_q);
  assign count_ext   = SW'(count_q);
  assign pos_ext     = SW'(in_item_i.position);
  assign req_ext     = SW'(in_item_i.drop_request);
  assign drop_n      = (req_ext < count_ext) ? req_ext : count_ext;
  assign ram_wdata_o = in_item_i.record_data[RECORD_BITS-1:0];

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    lost_d     = lost_q;
    ram_we_o   = 1'b0;
    ram_re_o   = 1'b0;
    ram_addr_o = head_q;
    found      = 1'b0;
    dropped    = '0;
    if (item_accept) begin
      unique case (in_item_i.opcode)
        orb_pkg::OP_PUSH: begin
          ram_we_o = 1'b1;
          if (!is_full) begin
            ram_addr_o = wrap(head_ext + count_ext);
            count_d    = count_q + CW'(1);
          end else begin
            head_d = wrap(head_ext + SW'(1));
            lost_d = lost_q + 32'd1;
          end
        end
        orb_pkg::OP_READ: begin
          if (pos_ext < count_ext) begin
            found      = 1'b1;
            ram_re_o   = 1'b1;
            ram_addr_o = wrap(head_ext + pos_ext);
          end
        end
        orb_pkg::OP_DROP: begin
          head_d  = wrap(head_ext + drop_n);
          count_d = count_q - drop_n[CW-1:0];
          dropped = drop_n;
        end
        orb_pkg::OP_CLEAR: begin
          head_d  = '0;
          count_d = '0;
          lost_d  = '0;
        end
      endcase
    end
    stage_d.valid       = item_accept;
    stage_d.found       = found;
    stage_d.dropped_now = dropped[8:0];
    stage_d.fill_count  = 9'(count_d);
    stage_d.lost_total  = lost_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      lost_q  <= '0;
      stage_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      lost_q  <= lost_d;
      stage_q <= stage_d;
    end
  end

  assign stage_o = stage_q;

endmodule

`default_nettype wire

>>> rtl/core/orb_back.sv
`default_nettype none

module orb_back #(
  parameter int RECORD_BITS = orb_pkg::RECORD_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire orb_pkg::stage_t        stage_i,
  input  wire logic [RECORD_BITS-1:0] ram_rdata_i,
  input  wire logic                   pop,
  output logic                        full_o,
  output logic                        empty_o,
  output orb_pkg::out_item_t          out_item_o
);

  localparam int PW = $clog2(orb_pkg::RES_DEPTH);
  localparam int NW = $clog2(orb_pkg::RES_DEPTH + 1);

  orb_pkg::out_item_t fifo_q [orb_pkg::RES_DEPTH];
  orb_pkg::out_item_t entry;
  logic [PW-1:0]      wr_ptr_q, rd_ptr_q;
  logic [NW-1:0]      cnt_q;
  logic               do_push, do_pop;

  assign do_push = stage_i.valid;
  assign do_pop  = pop & (cnt_q != '0);
  assign empty_o = (cnt_q == '0);
  // in-flight transaction holds a slot
  assign full_o  = ({1'b0, cnt_q} + (NW + 1)'(stage_i.valid))
                   >= (NW + 1)'(orb_pkg::RES_DEPTH);

  always_comb begin
    entry.found       = stage_i.found;
    entry.read_data   = stage_i.found ? orb_pkg::DATA_W'(ram_rdata_i) : '0;
    entry.dropped_now = stage_i.dropped_now;
    entry.fill_count  = stage_i.fill_count;
    entry.lost_total  = stage_i.lost_total;
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= entry;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(orb_pkg::RES_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(orb_pkg::RES_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + NW'(1);
      end else if (!do_push && do_pop) begin
        cnt_q <= cnt_q - NW'(1);
      end
    end
  end

  assign out_item_o = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

>>> rtl/core/overwriting_ring_buffer_unit.sv
// Each result is registered in the front stage, then written into the result queue, from
// whose head it is popped.
// Throughput: one transaction per cycle while results are popped; the record memory
// has one port and each transaction makes at most one access to it.
// full rises when the 4-entry result queue plus the transaction in flight reach 4.
// Reset (rst_ni, async, active low) clears head, fill count, lost counter and queues
// at once; the record memory is not cleared and needs no clearing pass.
`default_nettype none

module overwriting_ring_buffer_unit #(
  parameter int CAPACITY    = orb_pkg::CAPACITY_DEF,
  parameter int RECORD_BITS = orb_pkg::RECORD_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire orb_pkg::in_item_t  in_item_i,
  output logic                    empty,
  input  wire logic               pop,
  output orb_pkg::out_item_t      out_item_o
);

  logic                        ram_we, ram_re;
  logic [$clog2(CAPACITY)-1:0] ram_addr;
  logic [RECORD_BITS-1:0]      ram_wdata, ram_rdata;
  orb_pkg::stage_t             stage;

  orb_front #(
    .CAPACITY   (CAPACITY),
    .RECORD_BITS(RECORD_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full_i     (full),
    .in_item_i  (in_item_i),
    .ram_we_o   (ram_we),
    .ram_re_o   (ram_re),
    .ram_addr_o (ram_addr),
    .ram_wdata_o(ram_wdata),
    .stage_o    (stage)
  );

  orb_ram #(
    .WIDTH(RECORD_BITS),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .re_i   (ram_re),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  orb_back #(
    .RECORD_BITS(RECORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .stage_i    (stage),
    .ram_rdata_i(ram_rdata),
    .pop        (pop),
    .full_o     (full),
    .empty_o    (empty),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

>>> rtl/core/orb_checker.sv
`default_nettype none

module orb_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               push,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire orb_pkg::out_item_t out_item_o
);

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !out_item_o.found |-> out_item_o.read_data == '0)
    else $error("read miss carries nonzero data");

  a_hit_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_item_o.found |-> out_item_o.dropped_now == '0)
    else $error("read hit reports dropped records");

  a_idle_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty && !$past(push && !full) |-> !full)
    else $error("full with no transaction queued or in flight");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_item_o))
    else $error("waiting result changed or vanished");

endmodule

bind overwriting_ring_buffer_unit orb_checker u_orb_checker (.*);

`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int RING_SLOTS     = orb_pkg::CAPACITY_DEF;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    orb_pkg::in_item_t  stim;
    bit                 typed;
    orb_pkg::out_item_t want;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push_r = 1'b0;
  logic               pop_r = 1'b0;
  orb_pkg::in_item_t  in_r = '0;
  bit                 typed_r = 1'b0;
  orb_pkg::out_item_t want_r = '0;
  logic               full;
  logic               empty;
  orb_pkg::out_item_t out_r;

  logic [63:0] ring_mem [RING_SLOTS];
  logic [7:0]  ring_head = '0;
  logic [8:0]  ring_fill = '0;
  logic [31:0] ring_lost = '0;

  orb_pkg::out_item_t pending_results [$];
  int                 mismatches = 0;
  int                 idle_cycles = 0;
  int                 send_gap_pct = 0;
  int                 pop_gap_pct = 0;
  dir_row_t           directed_rows [$];

  overwriting_ring_buffer_unit dut (
    .clk_i     (clk),
    .rst_ni    (rst_ni),
    .push      (push_r),
    .full      (full),
    .in_item_i (in_r),
    .empty     (empty),
    .pop       (pop_r),
    .out_item_o(out_r)
  );

  always #10 clk = ~clk;

  task automatic apply_op(input orb_pkg::in_item_t t, output orb_pkg::out_item_t r);
    logic [7:0] slot;
    logic [8:0] n;
    r = '0;
    case (t.opcode)
      orb_pkg::OP_PUSH: begin
        if (ring_fill < RING_SLOTS) begin
          slot = ring_head + ring_fill[7:0];
          ring_mem[slot] = t.record_data;
          ring_fill = ring_fill + 9'd1;
        end else begin
          ring_mem[ring_head] = t.record_data;
          ring_head = ring_head + 8'd1;
          ring_lost = ring_lost + 32'd1;
        end
      end
      orb_pkg::OP_READ: begin
        if (t.position < ring_fill) begin
          slot = ring_head + t.position;
          r.found = 1'b1;
          r.read_data = ring_mem[slot];
        end
      end
      orb_pkg::OP_DROP: begin
        n = (t.drop_request < ring_fill) ? t.drop_request : ring_fill;
        ring_head = ring_head + n[7:0];
        ring_fill = ring_fill - n;
        r.dropped_now = n;
      end
      default: begin
        ring_head = '0;
        ring_fill = '0;
        ring_lost = '0;
      end
    endcase
    r.fill_count = ring_fill;
    r.lost_total = ring_lost;
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch on %s: expected %h, got %h", name, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    orb_pkg::out_item_t predicted;
    orb_pkg::out_item_t want;
    if (rst_ni) begin
      if (pop_r && !empty) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %h", out_r);
        end else begin
          want = pending_results.pop_front();
          check_field("found", 64'(want.found), 64'(out_r.found));
          check_field("read_data", want.read_data, out_r.read_data);
          check_field("dropped_now", 64'(want.dropped_now), 64'(out_r.dropped_now));
          check_field("fill_count", 64'(want.fill_count), 64'(out_r.fill_count));
          check_field("lost_total", 64'(want.lost_total), 64'(out_r.lost_total));
        end
      end
      if (push_r && !full) begin
        apply_op(in_r, predicted);
        pending_results.push_back(typed_r ? want_r : predicted);
      end
    end
  end

  always @(negedge clk) begin
    pop_r <= rst_ni && ($urandom_range(99) >= pop_gap_pct);
  end

  always @(posedge clk) begin
    if ((push_r && !full) || (pop_r && !empty) || !rst_ni) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", idle_cycles);
        $display("overwriting_ring_buffer_unit test failed");
        $finish;
      end
    end
  end

  function automatic dir_row_t mk_row(orb_pkg::op_e op, logic [63:0] d, logic [7:0] p,
                                      logic [8:0] q, logic f, logic [63:0] rd,
                                      logic [8:0] dn, logic [8:0] fc);
    dir_row_t row;
    row.stim = '{opcode: op, record_data: d, position: p, drop_request: q};
    row.typed = 1'b1;
    row.want = '{found: f, read_data: rd, dropped_now: dn, fill_count: fc,
                 lost_total: 32'd0};
    return row;
  endfunction

  function automatic orb_pkg::in_item_t rand_fields(orb_pkg::op_e op);
    orb_pkg::in_item_t t;
    t.opcode = op;
    t.record_data = {$urandom, $urandom};
    t.position = 8'($urandom);
    t.drop_request = 9'($urandom);
    return t;
  endfunction

  task automatic send_op(input orb_pkg::in_item_t t, input bit typed,
                         input orb_pkg::out_item_t want);
    while ($urandom_range(99) < send_gap_pct) begin
      push_r <= 1'b0;
      @(negedge clk);
    end
    push_r <= 1'b1;
    in_r <= t;
    typed_r <= typed;
    want_r <= want;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic send_mixed();
    orb_pkg::in_item_t t;
    int pick;
    pick = $urandom_range(99);
    if (pick < 45) t = rand_fields(orb_pkg::OP_PUSH);
    else if (pick < 80) t = rand_fields(orb_pkg::OP_READ);
    else if (pick < 97) t = rand_fields(orb_pkg::OP_DROP);
    else t = rand_fields(orb_pkg::OP_CLEAR);
    if (t.opcode == orb_pkg::OP_READ && ring_fill != 0 && $urandom_range(3) != 0) begin
      if ($urandom_range(4) == 0) t.position = 8'(ring_fill - 9'd1);
      else t.position = 8'($urandom_range(ring_fill - 1));
    end
    if (t.opcode == orb_pkg::OP_DROP) begin
      case ($urandom_range(9))
        7: t.drop_request = ring_fill;
        8: t.drop_request = 9'd256;
        9: ;
        default: t.drop_request = 9'($urandom_range(6));
      endcase
    end
    send_op(t, 1'b0, '0);
  endtask

  task automatic run_phase(input int send_pct, input int pop_pct);
    send_gap_pct = send_pct;
    pop_gap_pct = pop_pct;
    repeat (RING_SLOTS + $urandom_range(1, 8))
      send_op(rand_fields(orb_pkg::OP_PUSH), 1'b0, '0);
    repeat (100) send_mixed();
  endtask

  initial begin
    directed_rows.push_back(mk_row(orb_pkg::OP_READ, '1, 8'd0, 9'd0,
                                   1'b0, '0, 9'd0, 9'd0));
    directed_rows.push_back(mk_row(orb_pkg::OP_READ, '1, 8'd255, 9'd511,
                                   1'b0, '0, 9'd0, 9'd0));
    directed_rows.push_back(mk_row(orb_pkg::OP_DROP, '1, 8'd255, 9'd256,
                                   1'b0, '0, 9'd0, 9'd0));
    directed_rows.push_back(mk_row(orb_pkg::OP_DROP, '0, 8'd0, 9'd511,
                                   1'b0, '0, 9'd0, 9'd0));
    directed_rows.push_back(mk_row(orb_pkg::OP_CLEAR, '1, 8'd255, 9'd511,
                                   1'b0, '0, 9'd0, 9'd0));
    directed_rows.push_back(mk_row(orb_pkg::OP_PUSH, '1, 8'd255, 9'd511,
                                   1'b0, '0, 9'd0, 9'd1));
    directed_rows.push_back(mk_row(orb_pkg::OP_PUSH, '0, 8'd0, 9'd0,
                                   1'b0, '0, 9'd0, 9'd2));
    directed_rows.push_back(mk_row(orb_pkg::OP_PUSH, 64'h8000_0000_0000_0001, 8'd1, 9'd1,
                                   1'b0, '0, 9'd0, 9'd3));
    directed_rows.push_back(mk_row(orb_pkg::OP_READ, '0, 8'd0, 9'd511,
                                   1'b1, '1, 9'd0, 9'd3));
    directed_rows.push_back(mk_row(orb_pkg::OP_READ, '1, 8'd1, 9'd0,
                                   1'b1, '0, 9'd0, 9'd3));
    directed_rows.push_back(mk_row(orb_pkg::OP_READ, '0, 8'd2, 9'd0,
                                   1'b1, 64'h8000_0000_0000_0001, 9'd0, 9'd3));
    directed_rows.push_back(mk_row(orb_pkg::OP_READ, '1, 8'd3, 9'd0,
                                   1'b0, '0, 9'd0, 9'd3));
    directed_rows.push_back(mk_row(orb_pkg::OP_DROP, '1, 8'd255, 9'd0,
                                   1'b0, '0, 9'd0, 9'd3));
    directed_rows.push_back(mk_row(orb_pkg::OP_DROP, '0, 8'd0, 9'd1,
                                   1'b0, '0, 9'd1, 9'd2));
    directed_rows.push_back(mk_row(orb_pkg::OP_READ, '1, 8'd0, 9'd0,
                                   1'b1, '0, 9'd0, 9'd2));
    directed_rows.push_back(mk_row(orb_pkg::OP_DROP, '0, 8'd0, 9'd256,
                                   1'b0, '0, 9'd2, 9'd0));
    directed_rows.push_back(mk_row(orb_pkg::OP_READ, '1, 8'd0, 9'd0,
                                   1'b0, '0, 9'd0, 9'd0));
    directed_rows.push_back(mk_row(orb_pkg::OP_PUSH, 64'h5a5a_a5a5_0ff0_f00f, 8'd128,
                                   9'd128, 1'b0, '0, 9'd0, 9'd1));
    directed_rows.push_back(mk_row(orb_pkg::OP_READ, '0, 8'd0, 9'd0,
                                   1'b1, 64'h5a5a_a5a5_0ff0_f00f, 9'd0, 9'd1));
    directed_rows.push_back(mk_row(orb_pkg::OP_CLEAR, '0, 8'd0, 9'd0,
                                   1'b0, '0, 9'd0, 9'd0));
    directed_rows.push_back(mk_row(orb_pkg::OP_READ, '0, 8'd0, 9'd0,
                                   1'b0, '0, 9'd0, 9'd0));

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;
    @(negedge clk);

    send_gap_pct = 8;
    pop_gap_pct = 47;
    foreach (directed_rows[i])
      send_op(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);

    run_phase(8, 47);

    // let the buffer drain completely before the next phase
    push_r <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);

    run_phase(47, 8);
    run_phase(0, 0);

    push_r <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);

    if (mismatches == 0) begin
      $display("overwriting_ring_buffer_unit test passed");
    end else begin
      $display("overwriting_ring_buffer_unit test failed");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/orb_pkg.sv
rtl/core/orb_ram.sv
rtl/core/orb_front.sv
rtl/core/orb_back.sv
rtl/core/overwriting_ring_buffer_unit.sv
rtl/core/orb_checker.sv
tb/tb.sv
